// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion macros for the handle pool checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define HPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also checks during reset
`define HPA_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_pkg
// types, widths and codes shared by the handle pool allocator
// ----------------------------------------------------------------------------
package hpa_pkg;

    localparam int POOL_SIZE_DEF = 64;

    localparam int CMD_W       = 2;
    localparam int SOCK_W      = 16;
    localparam int SLOT_W      = 6;
    localparam int GEN_W       = 32;
    localparam int CNT_OUT_W   = 7;
    localparam int SOCK_ST_W   = 17;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CLOSE   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [GEN_W-1:0]     gen;
        logic                 inst;
        logic [SOCK_ST_W-1:0] sock;
    } t_slot_ent;

    localparam t_slot_ent SLOT_ENT_RST = '{gen: '0, inst: 1'b1, sock: '1};

    typedef struct packed {
        logic                 vld;
        logic [CMD_W-1:0]     cmd;
        logic                 err;
        logic [SLOT_W-1:0]    slot;
        logic [SOCK_W-1:0]    sock;
        logic [CNT_OUT_W-1:0] free_cnt;
    } t_op_ctl;

endpackage

// ===== src/hpa_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_stack
// free slot stack with top counter; pops or pushes at most one slot per item
// ----------------------------------------------------------------------------
module hpa_stack #(
    parameter int  POOL_SIZE = hpa_pkg::POOL_SIZE_DEF,
    localparam int IDX_W     = $clog2(POOL_SIZE),
    localparam int CNT_W     = $clog2(POOL_SIZE + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_acc,
    input  logic [hpa_pkg::CMD_W-1:0]    i_cmd,
    input  logic [hpa_pkg::SOCK_W-1:0]   i_sock,
    input  logic [hpa_pkg::SLOT_W-1:0]   i_slot,
    input  logic                         i_clr_busy,
    input  logic [IDX_W-1:0]             i_clr_addr,
    output hpa_pkg::t_op_ctl             o_ctl,
    output logic [IDX_W-1:0]             o_idx
);
    import hpa_pkg::*;

    logic [IDX_W-1:0] r_mem [POOL_SIZE];
    logic [CNT_W-1:0] r_top;
    logic [CNT_W-1:0] n_top;
    logic [CNT_W-1:0] top_m1;
    logic [IDX_W-1:0] slot_idx;
    logic [IDX_W-1:0] r_rd;
    logic [IDX_W-1:0] r_slot_idx;
    logic             r_sel_mem;
    logic             in_range;
    logic             is_give;
    logic             pop;
    logic             push;
    t_op_ctl          r_ctl;
    t_op_ctl          n_ctl;

    always_comb begin
        in_range = (32'(i_slot) < 32'(POOL_SIZE));
        slot_idx = IDX_W'(i_slot);
        top_m1   = r_top - CNT_W'(1);
        is_give  = (i_cmd == CMD_RELEASE) || (i_cmd == CMD_CLOSE);
        pop      = (i_cmd == CMD_ALLOC) && (r_top != '0);
        push     = is_give && in_range && (32'(r_top) < 32'(POOL_SIZE));
        if (pop) begin
            n_top = top_m1;
        end else if (push) begin
            n_top = r_top + CNT_W'(1);
        end else begin
            n_top = r_top;
        end
        n_ctl.vld      = i_acc;
        n_ctl.cmd      = i_cmd;
        n_ctl.err      = ((i_cmd == CMD_ALLOC) && (r_top == '0)) || (is_give && !in_range);
        n_ctl.slot     = i_slot;
        n_ctl.sock     = i_sock;
        n_ctl.free_cnt = CNT_OUT_W'(n_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= CNT_W'(POOL_SIZE);
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= n_ctl;
            if (i_acc) begin
                r_top <= n_top;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr_busy) begin
            r_mem[i_clr_addr] <= IDX_W'(POOL_SIZE - 1) - i_clr_addr;
        end else if (i_acc && push) begin
            r_mem[r_top[IDX_W-1:0]] <= slot_idx;
        end
        if (i_adv) begin
            r_sel_mem  <= (i_cmd == CMD_ALLOC);
            r_slot_idx <= slot_idx;
            if (i_acc && pop) begin
                r_rd <= r_mem[top_m1[IDX_W-1:0]];
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_idx = r_sel_mem ? r_rd : r_slot_idx;

endmodule

// ===== src/hpa_slot_tbl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_slot_tbl
// per-slot generation, instance and socket table with read-modify-write
// ----------------------------------------------------------------------------
module hpa_slot_tbl #(
    parameter int  POOL_SIZE = hpa_pkg::POOL_SIZE_DEF,
    localparam int IDX_W     = $clog2(POOL_SIZE)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  hpa_pkg::t_op_ctl               i_ctl,
    input  logic [IDX_W-1:0]               i_idx,
    input  logic                           i_clr_busy,
    input  logic [IDX_W-1:0]               i_clr_addr,
    output logic                           o_valid,
    output logic                           o_status,
    output logic [hpa_pkg::SLOT_W-1:0]     o_slot_out,
    output logic [hpa_pkg::GEN_W-1:0]      o_generation,
    output logic                           o_instance_bit,
    output logic [hpa_pkg::CNT_OUT_W-1:0]  o_free_count,
    output logic [hpa_pkg::SOCK_W-1:0]     o_close_sock
);
    import hpa_pkg::*;

    t_slot_ent        r_mem [POOL_SIZE];
    t_slot_ent        r_rd;
    t_slot_ent        r_wb_ent;
    t_slot_ent        cur;
    t_slot_ent        n_ent;
    t_op_ctl          r_ctl;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_wb_idx;
    logic             r_wb_vld;
    logic             wr;
    logic             r_out_vld;
    logic             n_status;
    logic [SLOT_W-1:0] n_slot_out;
    logic [GEN_W-1:0]  n_gen;
    logic              n_inst;
    logic [SOCK_W-1:0] n_close;

    // newest copy of the entry: last write wins over the stale read
    always_comb begin
        cur   = (r_wb_vld && (r_wb_idx == r_idx)) ? r_wb_ent : r_rd;
        wr    = r_ctl.vld && !r_ctl.err
                && ((r_ctl.cmd == CMD_ALLOC) || (r_ctl.cmd == CMD_RELEASE)
                    || (r_ctl.cmd == CMD_CLOSE));
        n_ent     = cur;
        n_ent.gen = cur.gen + GEN_W'(1);
        n_close   = '0;
        case (r_ctl.cmd)
            CMD_ALLOC: begin
                n_ent.inst = ~cur.inst;
                n_ent.sock = SOCK_ST_W'(r_ctl.sock);
            end
            CMD_CLOSE: begin
                n_ent.sock = '1;
                n_close    = cur.sock[SOCK_W-1:0];
            end
            default: begin
            end
        endcase
        n_status   = r_ctl.err;
        n_slot_out = '0;
        n_gen      = '0;
        n_inst     = 1'b0;
        if (wr) begin
            n_slot_out = SLOT_W'(r_idx);
            n_gen      = n_ent.gen;
            n_inst     = n_ent.inst;
        end else if (r_ctl.err && (r_ctl.cmd != CMD_ALLOC)) begin
            n_slot_out = r_ctl.slot;
        end
        if (!wr) begin
            n_close = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl     <= '0;
            r_wb_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_adv) begin
            r_ctl     <= i_ctl;
            r_wb_vld  <= wr;
            r_out_vld <= r_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr_busy) begin
            r_mem[i_clr_addr] <= SLOT_ENT_RST;
        end else if (i_adv && wr) begin
            r_mem[r_idx] <= n_ent;
        end
        if (i_adv) begin
            r_idx    <= i_idx;
            r_wb_idx <= r_idx;
            r_wb_ent <= n_ent;
            if (i_ctl.vld && !i_ctl.err) begin
                r_rd <= r_mem[i_idx];
            end
            o_status       <= n_status;
            o_slot_out     <= n_slot_out;
            o_generation   <= n_gen;
            o_instance_bit <= n_inst;
            o_free_count   <= r_ctl.free_cnt;
            o_close_sock   <= n_close;
        end
    end

    assign o_valid = r_out_vld;

endmodule

// ===== src/handle_pool_allocator.sv =====
`timescale 1ns / 1ps
// an accepted item passes the stack and slot table stages and the output
// registers to o_valid; throughput: one item per cycle while o_stall is low;
// the free stack moves at accept, the slot table read-modify-write completes
// in the last stage with one-entry forwarding; reset: o_stall stays high while
// both tables are swept to their initial contents, then items are taken
// ----------------------------------------------------------------------------
// handle_pool_allocator
// slot pool with LIFO free list, generation counters and instance bits
// ----------------------------------------------------------------------------
module handle_pool_allocator #(
    parameter int  POOL_SIZE = hpa_pkg::POOL_SIZE_DEF,
    localparam int IDX_W     = $clog2(POOL_SIZE)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [hpa_pkg::CMD_W-1:0]      i_cmd,
    input  logic [hpa_pkg::SOCK_W-1:0]     i_sock,
    input  logic [hpa_pkg::SLOT_W-1:0]     i_slot,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_status,
    output logic [hpa_pkg::SLOT_W-1:0]     o_slot_out,
    output logic [hpa_pkg::GEN_W-1:0]      o_generation,
    output logic                           o_instance_bit,
    output logic [hpa_pkg::CNT_OUT_W-1:0]  o_free_count,
    output logic [hpa_pkg::SOCK_W-1:0]     o_close_sock
);
    import hpa_pkg::*;

    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;
    logic             adv;
    logic             acc;
    t_op_ctl          ctl_b;
    logic [IDX_W-1:0] idx_b;

    assign adv     = !o_valid || !i_stall;
    assign o_stall = r_clr_busy || !adv;
    assign acc     = i_valid && !o_stall;

    // initial sweep of both tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (r_clr_addr == IDX_W'(POOL_SIZE - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    hpa_stack #(.POOL_SIZE(POOL_SIZE)) u_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_acc      (acc),
        .i_cmd      (i_cmd),
        .i_sock     (i_sock),
        .i_slot     (i_slot),
        .i_clr_busy (r_clr_busy),
        .i_clr_addr (r_clr_addr),
        .o_ctl      (ctl_b),
        .o_idx      (idx_b)
    );

    hpa_slot_tbl #(.POOL_SIZE(POOL_SIZE)) u_slot_tbl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_ctl          (ctl_b),
        .i_idx          (idx_b),
        .i_clr_busy     (r_clr_busy),
        .i_clr_addr     (r_clr_addr),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_slot_out     (o_slot_out),
        .o_generation   (o_generation),
        .o_instance_bit (o_instance_bit),
        .o_free_count   (o_free_count),
        .o_close_sock   (o_close_sock)
    );

endmodule

// ===== src/hpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_checker
// port-level checks on the handle pool allocator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpa_checker #(
    parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic                           o_status,
    input logic [hpa_pkg::GEN_W-1:0]      o_generation,
    input logic                           o_instance_bit,
    input logic [hpa_pkg::CNT_OUT_W-1:0]  o_free_count,
    input logic [hpa_pkg::SOCK_W-1:0]     o_close_sock
);
    import hpa_pkg::*;

    `HPA_ASSERT_RST(a_rst_no_out, i_clk, !i_rst_n |=> !o_valid, "item out right after reset")

    `HPA_ASSERT(a_hold_count, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_free_count), "stalled item changed")

    `HPA_ASSERT(a_err_clean, i_clk, i_rst_n, o_valid && o_status |-> (o_generation == '0) && !o_instance_bit && (o_close_sock == '0), "error item carries slot data")

    `HPA_ASSERT(a_count_max, i_clk, i_rst_n, o_valid |-> (32'(o_free_count) <= 32'(POOL_SIZE)), "free count above pool size")

endmodule

bind handle_pool_allocator hpa_checker #(.POOL_SIZE(POOL_SIZE)) u_hpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_generation   (o_generation),
    .o_instance_bit (o_instance_bit),
    .o_free_count   (o_free_count),
    .o_close_sock   (o_close_sock)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the handle pool allocator item by item: an in-bench model of the free
// stack and slot table predicts every reply, which is compared field by field
// as it leaves the block, under several idle and stall mixes and a long hold
// ----------------------------------------------------------------------------
module testbench;
    import hpa_pkg::*;

    localparam int POOL = POOL_SIZE_DEF;
    localparam int PLAN = 0;
    localparam int LIVE = 1;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 367;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SOCK_W-1:0] sock;
        logic [SLOT_W-1:0] slot;
    } t_item;

    typedef struct packed {
        logic                 status;
        logic [SLOT_W-1:0]    slot;
        logic [GEN_W-1:0]     gen;
        logic                 inst;
        logic [CNT_OUT_W-1:0] free_cnt;
        logic [SOCK_W-1:0]    close_sock;
    } t_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [CMD_W-1:0]     i_cmd = '0;
    logic [SOCK_W-1:0]    i_sock = '0;
    logic [SLOT_W-1:0]    i_slot = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_status;
    logic [SLOT_W-1:0]    o_slot_out;
    logic [GEN_W-1:0]     o_generation;
    logic                 o_instance_bit;
    logic [CNT_OUT_W-1:0] o_free_count;
    logic [SOCK_W-1:0]    o_close_sock;

    handle_pool_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_sock         (i_sock),
        .i_slot         (i_slot),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_slot_out     (o_slot_out),
        .o_generation   (o_generation),
        .o_instance_bit (o_instance_bit),
        .o_free_count   (o_free_count),
        .o_close_sock   (o_close_sock)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // two copies of the pool: one steers stimulus, one follows accepted items
    logic [SLOT_W-1:0]    free_stk  [2][POOL];
    int unsigned          free_top  [2];
    logic [GEN_W-1:0]     gen_tbl   [2][POOL];
    logic                 inst_tbl  [2][POOL];
    logic [SOCK_ST_W-1:0] sock_tbl  [2][POOL];

    t_item  cmd_queue[$];
    t_reply due_replies[$];
    logic [SLOT_W-1:0] held_slots[$];

    int  planned = 0;
    int  counted = 0;
    int  accepted = 0;
    int  fail_count = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    logic rx_hold = 1'b0;
    logic in_fire = 1'b0;
    t_item  nxt;
    t_reply want;

    function automatic void pool_reset(input int c);
        for (int i = 0; i < POOL; i++) begin
            free_stk[c][i] = SLOT_W'(POOL - 1 - i);
            gen_tbl[c][i]  = '0;
            inst_tbl[c][i] = 1'b1;
            sock_tbl[c][i] = '1;
        end
        free_top[c] = POOL;
    endfunction

    function automatic t_reply pool_apply(input int c, input t_item it);
        t_reply r;
        int g;
        r = '0;
        case (it.cmd)
            CMD_ALLOC: begin
                if (free_top[c] == 0) begin
                    r.status = 1'b1;
                end else begin
                    free_top[c]--;
                    g = int'(free_stk[c][free_top[c]]) % POOL;
                    sock_tbl[c][g] = {1'b0, it.sock};
                    inst_tbl[c][g] = ~inst_tbl[c][g];
                    gen_tbl[c][g]  = gen_tbl[c][g] + 1;
                    r.slot = SLOT_W'(g);
                    r.gen  = gen_tbl[c][g];
                    r.inst = inst_tbl[c][g];
                end
            end
            CMD_RELEASE, CMD_CLOSE: begin
                g = int'(it.slot);
                r.slot = it.slot;
                if (g >= POOL) begin
                    r.status = 1'b1;
                end else begin
                    if (it.cmd == CMD_CLOSE) begin
                        r.close_sock = sock_tbl[c][g][SOCK_W-1:0];
                        sock_tbl[c][g] = '1;
                    end
                    // a push onto a full stack is dropped
                    if (free_top[c] < POOL) begin
                        free_stk[c][free_top[c]] = it.slot;
                        free_top[c]++;
                    end
                    gen_tbl[c][g] = gen_tbl[c][g] + 1;
                    r.gen  = gen_tbl[c][g];
                    r.inst = inst_tbl[c][g];
                end
            end
            default: begin
            end
        endcase
        r.free_cnt = CNT_OUT_W'(free_top[c]);
        return r;
    endfunction

    task automatic plan(input logic [CMD_W-1:0] c, input logic [SOCK_W-1:0] s,
                        input logic [SLOT_W-1:0] sl);
        t_item  it;
        t_reply r;
        it = '{cmd: c, sock: s, slot: sl};
        r = pool_apply(PLAN, it);
        cmd_queue.push_back(it);
        planned++;
        if (c != CMD_UNUSED)
            counted++;
        if (c == CMD_ALLOC && !r.status)
            held_slots.push_back(r.slot);
        if ((c == CMD_RELEASE || c == CMD_CLOSE) && !r.status) begin
            for (int k = 0; k < held_slots.size(); k++) begin
                if (held_slots[k] == sl) begin
                    held_slots.delete(k);
                    break;
                end
            end
        end
    endtask

    task automatic run_phase(input int n);
        int target;
        int pick;
        int len;
        int k;
        target = counted + n;
        while (counted < target) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                // long bursts drain the pool and run into empty
                len = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
                repeat (len) plan(CMD_ALLOC, SOCK_W'($urandom), SLOT_W'($urandom));
            end else if (pick < 88) begin
                len = $urandom_range(1, 12);
                repeat (len) begin
                    if (held_slots.size() != 0) begin
                        k = $urandom_range(held_slots.size() - 1);
                        plan($urandom_range(1) ? CMD_CLOSE : CMD_RELEASE,
                             SOCK_W'($urandom), held_slots[k]);
                    end
                end
            end else begin
                // noise: any command on any slot, free ones included
                repeat ($urandom_range(1, 4))
                    plan(CMD_W'($urandom_range(3)), SOCK_W'($urandom), SLOT_W'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (accepted != planned) @(negedge i_clk);
        while (due_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
        $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, exp_v, $time);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_valid && !o_stall;
        if (in_fire) begin
            due_replies.push_back(pool_apply(LIVE, '{cmd: i_cmd, sock: i_sock, slot: i_slot}));
            accepted++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_replies.size() == 0) begin
                report("unexpected reply, slot", 32'(o_slot_out), 32'd0);
            end else begin
                want = due_replies.pop_front();
                if (o_status !== want.status)
                    report("status", 32'(o_status), 32'(want.status));
                if (o_slot_out !== want.slot)
                    report("slot_out", 32'(o_slot_out), 32'(want.slot));
                if (o_generation !== want.gen)
                    report("generation", o_generation, want.gen);
                if (o_instance_bit !== want.inst)
                    report("instance_bit", 32'(o_instance_bit), 32'(want.inst));
                if (o_free_count !== want.free_cnt)
                    report("free_count", 32'(o_free_count), 32'(want.free_cnt));
                if (o_close_sock !== want.close_sock)
                    report("close_sock", 32'(o_close_sock), 32'(want.close_sock));
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
        if (i_rst_n && (!i_valid || in_fire)) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = cmd_queue.pop_front();
                i_cmd   <= nxt.cmd;
                i_sock  <= nxt.sock;
                i_slot  <= nxt.slot;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        pool_reset(PLAN);
        pool_reset(LIVE);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full stack, no socket, duplicates, unused command
        plan(CMD_RELEASE, 16'h0000, 6'd5);
        plan(CMD_CLOSE,   16'h0000, 6'd63);
        plan(CMD_UNUSED,  16'hffff, 6'd63);
        plan(CMD_ALLOC,   16'h0000, 6'd0);
        plan(CMD_ALLOC,   16'hffff, 6'd63);
        plan(CMD_ALLOC,   16'h5a3c, 6'd0);
        plan(CMD_CLOSE,   16'h0000, 6'd1);
        plan(CMD_CLOSE,   16'h0000, 6'd1);
        plan(CMD_RELEASE, 16'h0000, 6'd0);
        plan(CMD_CLOSE,   16'h0000, 6'd0);
        plan(CMD_ALLOC,   16'h8001, 6'd0);
        plan(CMD_ALLOC,   16'h7ffe, 6'd63);
        plan(CMD_ALLOC,   16'h1234, 6'd21);
        plan(CMD_RELEASE, 16'hffff, 6'd40);
        plan(CMD_ALLOC,   16'ha5a5, 6'd0);
        plan(CMD_ALLOC,   16'h0001, 6'd0);
        plan(CMD_CLOSE,   16'h0000, 6'd2);
        plan(CMD_UNUSED,  16'h0000, 6'd0);
        drain();

        run_phase(PHASE_ITEMS);
        drain();

        tx_idle_pct = 53;
        run_phase(PHASE_ITEMS);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 53;
        run_phase(PHASE_ITEMS);
        drain();

        tx_idle_pct = 34;
        rx_idle_pct = 34;
        run_phase(PHASE_ITEMS);
        drain();

        // receiver holds off while items keep coming, back pressure builds
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        run_phase(PHASE_ITEMS);
        drain();

        repeat (16) @(negedge i_clk);
        if (due_replies.size() != 0)
            report("replies never seen", 32'(due_replies.size()), 32'd0);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
